### design/assert_macros.svh
// Assertion macros shared by the checker files.
// Each macro takes a label, clock, active-low reset, the condition, the
// expected result and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/igbt_pkg.sv
// ----------------------------------------------------------------------------
// igbt_pkg
// Shared constants, codes and controller/datapath interface types of the
// greedy IoU box tracker.
// ----------------------------------------------------------------------------
package igbt_pkg;

    // Table sizes
    localparam int MAX_TRACKS  = 16;
    localparam int MAX_PENDING = 16;
    localparam int TIDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int TCNT_W = $clog2(MAX_TRACKS + 1);
    localparam int PIDX_W = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
    localparam int PCNT_W = $clog2(MAX_PENDING + 1);

    // Request codes
    localparam logic [1:0] REQ_DETECT    = 2'd0;
    localparam logic [1:0] REQ_FRAME_END = 2'd1;
    localparam logic [1:0] REQ_PREDICT   = 2'd2;
    localparam logic [1:0] REQ_CLEAR     = 2'd3;

    // Register indexes
    localparam logic [1:0] CFG_SMOOTH   = 2'd0;
    localparam logic [1:0] CFG_THRESH   = 2'd1;
    localparam logic [1:0] CFG_MAX_LOST = 2'd2;

    // Register reset values
    localparam logic [8:0] SMOOTH_RST   = 9'd128;
    localparam logic [8:0] THRESH_RST   = 9'd77;
    localparam logic [7:0] MAX_LOST_RST = 8'd10;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DET_INIT,
        ST_DET_A,
        ST_DET_B,
        ST_DET_C,
        ST_DET_D,
        ST_DET_E,
        ST_DET_DONE,
        ST_DET_MATCH,
        ST_FE_SCAN,
        ST_FE_APP,
        ST_FE_DONE,
        ST_PRED,
        ST_PRED_EMPTY,
        ST_CLEAR
    } ctrl_state_t;

    // Datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT,
        OP_IOU_A,
        OP_IOU_B,
        OP_IOU_C,
        OP_IOU_D,
        OP_IOU_E,
        OP_EMA,
        OP_MATCH,
        OP_PUSH,
        OP_DROP,
        OP_SCAN,
        OP_APPEND,
        OP_CLR_MATCH,
        OP_EMIT,
        OP_EMIT_EMPTY
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic [TIDX_W-1:0]   rd_idx;
        logic [TIDX_W-1:0]   wr_idx;
        logic [PIDX_W-1:0]   pend_idx;
        logic                last;
    } dp_cmd_t;

    typedef struct packed {
        logic found;     // a track beat the threshold
        logic keep;      // scanned track survives frame end
        logic out_busy;  // output register full and stalled
    } dp_status_t;

endpackage

### design/igbt_ctrl.sv
// ----------------------------------------------------------------------------
// igbt_ctrl
// Sequencer of the tracker: walks the track table for each request and
// issues datapath operations. Holds table fill and pending fill.
// ----------------------------------------------------------------------------
module igbt_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            req_type,
    input  igbt_pkg::dp_status_t  status,
    output igbt_pkg::dp_cmd_t     cmd
);

    igbt_pkg::ctrl_state_t state_reg, state_next;
    logic [igbt_pkg::TCNT_W-1:0] i_reg, i_next;
    logic [igbt_pkg::TCNT_W-1:0] w_reg, w_next;
    logic [igbt_pkg::TCNT_W-1:0] count_reg, count_next;
    logic [igbt_pkg::PCNT_W-1:0] j_reg, j_next;
    logic [igbt_pkg::PCNT_W-1:0] pcount_reg, pcount_next;
    logic                        accept;
    logic                        pred_last;

    assign in_stall  = (state_reg != igbt_pkg::ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign pred_last = (igbt_pkg::TCNT_W'(i_reg + 1'b1) == count_reg);

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= igbt_pkg::ST_IDLE;
            i_reg      <= '0;
            w_reg      <= '0;
            count_reg  <= '0;
            j_reg      <= '0;
            pcount_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            i_reg      <= i_next;
            w_reg      <= w_next;
            count_reg  <= count_next;
            j_reg      <= j_next;
            pcount_reg <= pcount_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        i_next       = i_reg;
        w_next       = w_reg;
        count_next   = count_reg;
        j_next       = j_reg;
        pcount_next  = pcount_reg;
        cmd          = '0;
        cmd.op       = igbt_pkg::OP_NONE;
        cmd.rd_idx   = i_reg[igbt_pkg::TIDX_W-1:0];
        cmd.wr_idx   = w_reg[igbt_pkg::TIDX_W-1:0];
        cmd.pend_idx = j_reg[igbt_pkg::PIDX_W-1:0];
        cmd.last     = 1'b0;
        case (state_reg)
            igbt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.op = igbt_pkg::OP_LOAD;
                    i_next = '0;
                    w_next = '0;
                    j_next = '0;
                    case (req_type)
                        igbt_pkg::REQ_DETECT:    state_next = igbt_pkg::ST_DET_INIT;
                        igbt_pkg::REQ_FRAME_END: state_next = igbt_pkg::ST_FE_SCAN;
                        igbt_pkg::REQ_PREDICT:
                        begin
                            if (count_reg == '0)
                                state_next = igbt_pkg::ST_PRED_EMPTY;
                            else
                                state_next = igbt_pkg::ST_PRED;
                        end
                        default:                 state_next = igbt_pkg::ST_CLEAR;
                    endcase
                end
            end
            igbt_pkg::ST_DET_INIT:
            begin
                cmd.op     = igbt_pkg::OP_INIT;
                state_next = igbt_pkg::ST_DET_A;
            end
            igbt_pkg::ST_DET_A:
            begin
                if (i_reg == count_reg)
                    state_next = igbt_pkg::ST_DET_DONE;
                else
                begin
                    cmd.op     = igbt_pkg::OP_IOU_A;
                    state_next = igbt_pkg::ST_DET_B;
                end
            end
            igbt_pkg::ST_DET_B:
            begin
                cmd.op     = igbt_pkg::OP_IOU_B;
                state_next = igbt_pkg::ST_DET_C;
            end
            igbt_pkg::ST_DET_C:
            begin
                cmd.op     = igbt_pkg::OP_IOU_C;
                state_next = igbt_pkg::ST_DET_D;
            end
            igbt_pkg::ST_DET_D:
            begin
                cmd.op     = igbt_pkg::OP_IOU_D;
                state_next = igbt_pkg::ST_DET_E;
            end
            igbt_pkg::ST_DET_E:
            begin
                cmd.op     = igbt_pkg::OP_IOU_E;
                i_next     = igbt_pkg::TCNT_W'(i_reg + 1'b1);
                state_next = igbt_pkg::ST_DET_A;
            end
            igbt_pkg::ST_DET_DONE:
            begin
                state_next = igbt_pkg::ST_IDLE;
                if (status.found)
                begin
                    cmd.op     = igbt_pkg::OP_EMA;
                    state_next = igbt_pkg::ST_DET_MATCH;
                end
                else if (pcount_reg != igbt_pkg::PCNT_W'(igbt_pkg::MAX_PENDING))
                begin
                    cmd.op       = igbt_pkg::OP_PUSH;
                    cmd.pend_idx = pcount_reg[igbt_pkg::PIDX_W-1:0];
                    pcount_next  = igbt_pkg::PCNT_W'(pcount_reg + 1'b1);
                end
                else
                    cmd.op = igbt_pkg::OP_DROP;
            end
            igbt_pkg::ST_DET_MATCH:
            begin
                cmd.op     = igbt_pkg::OP_MATCH;
                state_next = igbt_pkg::ST_IDLE;
            end
            // Age and compact the table in place
            igbt_pkg::ST_FE_SCAN:
            begin
                if (i_reg == count_reg)
                    state_next = igbt_pkg::ST_FE_APP;
                else
                begin
                    cmd.op = igbt_pkg::OP_SCAN;
                    i_next = igbt_pkg::TCNT_W'(i_reg + 1'b1);
                    if (status.keep)
                        w_next = igbt_pkg::TCNT_W'(w_reg + 1'b1);
                end
            end
            // Append pending boxes as new tracks
            igbt_pkg::ST_FE_APP:
            begin
                if (j_reg == pcount_reg)
                    state_next = igbt_pkg::ST_FE_DONE;
                else if (w_reg == igbt_pkg::TCNT_W'(igbt_pkg::MAX_TRACKS))
                begin
                    cmd.op     = igbt_pkg::OP_DROP;
                    state_next = igbt_pkg::ST_FE_DONE;
                end
                else
                begin
                    cmd.op = igbt_pkg::OP_APPEND;
                    w_next = igbt_pkg::TCNT_W'(w_reg + 1'b1);
                    j_next = igbt_pkg::PCNT_W'(j_reg + 1'b1);
                end
            end
            igbt_pkg::ST_FE_DONE:
            begin
                cmd.op      = igbt_pkg::OP_CLR_MATCH;
                count_next  = w_reg;
                pcount_next = '0;
                state_next  = igbt_pkg::ST_IDLE;
            end
            igbt_pkg::ST_PRED:
            begin
                if (!status.out_busy)
                begin
                    cmd.op     = igbt_pkg::OP_EMIT;
                    cmd.wr_idx = i_reg[igbt_pkg::TIDX_W-1:0];
                    cmd.last   = pred_last;
                    i_next     = igbt_pkg::TCNT_W'(i_reg + 1'b1);
                    if (pred_last)
                        state_next = igbt_pkg::ST_IDLE;
                end
            end
            igbt_pkg::ST_PRED_EMPTY:
            begin
                if (!status.out_busy)
                begin
                    cmd.op     = igbt_pkg::OP_EMIT_EMPTY;
                    cmd.last   = 1'b1;
                    state_next = igbt_pkg::ST_IDLE;
                end
            end
            igbt_pkg::ST_CLEAR:
            begin
                cmd.op     = igbt_pkg::OP_CLR_MATCH;
                count_next = '0;
                state_next = igbt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = igbt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### design/igbt_datapath.sv
// ----------------------------------------------------------------------------
// igbt_datapath
// Track and pending stores, IoU compare unit, EMA update, frame-end
// compaction, predict arithmetic, configuration and the output register.
// ----------------------------------------------------------------------------
module igbt_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  igbt_pkg::dp_cmd_t     cmd,
    output igbt_pkg::dp_status_t  status,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [8:0]            cfg_data,
    input  logic signed [15:0]    box_x,
    input  logic signed [15:0]    box_y,
    input  logic [15:0]           box_w,
    input  logic [15:0]           box_h,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  track_valid,
    output logic [15:0]           track_id,
    output logic signed [15:0]    out_x,
    output logic signed [15:0]    out_y,
    output logic [15:0]           out_w,
    output logic [15:0]           out_h,
    output logic signed [15:0]    vel_x,
    output logic signed [15:0]    vel_y,
    output logic [7:0]            lost_count,
    output logic                  dropped_flag,
    output logic                  last
);

    localparam int NT = igbt_pkg::MAX_TRACKS;
    localparam int NP = igbt_pkg::MAX_PENDING;

    // Saturate to 16 bits signed
    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'sd32767)
            r = 16'sh7fff;
        else if (v < -20'sd32768)
            r = -16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    // Twice the center coordinate
    function automatic logic signed [19:0] center2(input logic signed [15:0] p,
                                                   input logic [15:0] s);
        logic signed [19:0] r;
        r = $signed({{3{p[15]}}, p, 1'b0}) + $signed({4'b0000, s});
        return r;
    endfunction

    // Velocity decay toward zero by 230/256
    function automatic logic signed [15:0] decay(input logic signed [15:0] v);
        logic [15:0] m;
        logic [23:0] p;
        logic [15:0] r;
        m = v[15] ? 16'(-v) : v;
        p = m * 8'd230;
        r = p[23:8];
        return v[15] ? 16'(-r) : r;
    endfunction

    // Configuration
    logic [8:0] smooth_reg;
    logic [8:0] thresh_reg;
    logic [7:0] max_lost_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_reg   <= igbt_pkg::SMOOTH_RST;
            thresh_reg   <= igbt_pkg::THRESH_RST;
            max_lost_reg <= igbt_pkg::MAX_LOST_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                igbt_pkg::CFG_SMOOTH:   smooth_reg   <= cfg_data;
                igbt_pkg::CFG_THRESH:   thresh_reg   <= cfg_data;
                igbt_pkg::CFG_MAX_LOST: max_lost_reg <= cfg_data[7:0];
                default:                ;
            endcase
        end
    end

    // Stores
    logic [15:0]        id_mem [NT];
    logic signed [15:0] bx_mem [NT];
    logic signed [15:0] by_mem [NT];
    logic [15:0]        bw_mem [NT];
    logic [15:0]        bh_mem [NT];
    logic signed [15:0] vx_mem [NT];
    logic signed [15:0] vy_mem [NT];
    logic [7:0]         lost_mem [NT];
    logic signed [15:0] px_mem [NP];
    logic signed [15:0] py_mem [NP];
    logic [15:0]        pw_mem [NP];
    logic [15:0]        ph_mem [NP];
    logic [NT-1:0]      matched_reg;
    logic [15:0]        next_id_reg;
    logic               sticky_reg;

    // Detection and compare registers
    logic signed [15:0] det_x_reg, det_y_reg;
    logic [15:0]        det_w_reg, det_h_reg;
    logic [31:0]        da_reg, ta_reg, inter_reg;
    logic [15:0]        ow_reg, oh_reg;
    logic               skip_reg;
    logic [32:0]        uni_reg, best_u_reg;
    logic [31:0]        best_i_reg;
    logic [63:0]        prod1_reg, prod2_reg;
    logic               found_reg;
    logic [igbt_pkg::TIDX_W-1:0] best_idx_reg;
    logic signed [15:0] nb_reg [4];
    logic               out_valid_reg;

    // Entry selection
    logic [igbt_pkg::TIDX_W-1:0] ridx, widx;
    logic use_best;

    assign use_best = (cmd.op == igbt_pkg::OP_EMA) || (cmd.op == igbt_pkg::OP_MATCH);
    assign ridx     = use_best ? best_idx_reg : cmd.rd_idx;
    assign widx     = use_best ? best_idx_reg : cmd.wr_idx;

    logic signed [15:0] t_x, t_y, t_vx, t_vy;
    logic [15:0]        t_w, t_h, t_id;
    logic [7:0]         t_lost;
    logic               t_matched;

    assign t_x       = bx_mem[ridx];
    assign t_y       = by_mem[ridx];
    assign t_w       = bw_mem[ridx];
    assign t_h       = bh_mem[ridx];
    assign t_vx      = vx_mem[ridx];
    assign t_vy      = vy_mem[ridx];
    assign t_id      = id_mem[ridx];
    assign t_lost    = lost_mem[ridx];
    assign t_matched = matched_reg[ridx];

    // Overlap extents
    logic signed [17:0] dl, dr, dt, db, tl, tr, tt, tb;
    logic signed [17:0] ov_w, ov_h;
    logic               ov_empty;

    always_comb
    begin
        dl = $signed({{2{det_x_reg[15]}}, det_x_reg});
        dt = $signed({{2{det_y_reg[15]}}, det_y_reg});
        tl = $signed({{2{t_x[15]}}, t_x});
        tt = $signed({{2{t_y[15]}}, t_y});
        dr = dl + $signed({2'b00, det_w_reg});
        db = dt + $signed({2'b00, det_h_reg});
        tr = tl + $signed({2'b00, t_w});
        tb = tt + $signed({2'b00, t_h});
        ov_w = ((dr < tr) ? dr : tr) - ((dl > tl) ? dl : tl);
        ov_h = ((db < tb) ? db : tb) - ((dt > tt) ? dt : tt);
        ov_empty = (ov_w <= 18'sd0) || (ov_h <= 18'sd0);
    end

    // Ratio compare on full 65-bit products
    logic [64:0] p1, p2;
    logic        better;

    always_comb
    begin
        p1 = {1'b0, prod1_reg} + (best_u_reg[32] ? {1'b0, inter_reg, 32'd0} : 65'd0);
        p2 = {1'b0, prod2_reg} + (uni_reg[32] ? {1'b0, best_i_reg, 32'd0} : 65'd0);
        better = !skip_reg && (p1 > p2);
    end

    // EMA lanes
    logic [8:0]         s_eff, s_inv;
    logic signed [16:0] ema_old [4];
    logic signed [16:0] ema_det [4];
    logic signed [27:0] ema_sum [4];
    logic signed [15:0] ema_new [4];

    always_comb
    begin
        s_eff = (smooth_reg > 9'd256) ? 9'd256 : smooth_reg;
        s_inv = 9'd256 - s_eff;
        ema_old[0] = $signed({t_x[15], t_x});
        ema_old[1] = $signed({t_y[15], t_y});
        ema_old[2] = $signed({1'b0, t_w});
        ema_old[3] = $signed({1'b0, t_h});
        ema_det[0] = $signed({det_x_reg[15], det_x_reg});
        ema_det[1] = $signed({det_y_reg[15], det_y_reg});
        ema_det[2] = $signed({1'b0, det_w_reg});
        ema_det[3] = $signed({1'b0, det_h_reg});
        for (int k = 0; k < 4; k++)
        begin
            ema_sum[k] = 28'(ema_old[k] * $signed({1'b0, s_inv}))
                       + 28'(ema_det[k] * $signed({1'b0, s_eff}));
            ema_new[k] = ema_sum[k][23:8];
        end
    end

    // Center-difference velocity of a matched track
    logic signed [19:0] dvx, dvy;
    logic signed [15:0] mvx, mvy;

    always_comb
    begin
        dvx = center2(nb_reg[0], nb_reg[2]) - center2(t_x, t_w);
        dvy = center2(nb_reg[1], nb_reg[3]) - center2(t_y, t_h);
        mvx = sat16(dvx >>> 1);
        mvy = sat16(dvy >>> 1);
    end

    // Frame-end aging
    logic [7:0] lost_n;
    logic       keep;

    assign lost_n = (!t_matched && (t_lost != 8'hff)) ? 8'(t_lost + 1'b1) : t_lost;
    assign keep   = (lost_n <= max_lost_reg);

    // Predict step
    logic signed [15:0] pr_x, pr_y, pr_vx, pr_vy;

    always_comb
    begin
        if (t_lost != 8'd0)
        begin
            pr_x  = sat16($signed({{4{t_x[15]}}, t_x}) + $signed({{4{t_vx[15]}}, t_vx}));
            pr_y  = sat16($signed({{4{t_y[15]}}, t_y}) + $signed({{4{t_vy[15]}}, t_vy}));
            pr_vx = decay(t_vx);
            pr_vy = decay(t_vy);
        end
        else
        begin
            pr_x  = t_x;
            pr_y  = t_y;
            pr_vx = t_vx;
            pr_vy = t_vy;
        end
    end

    // Control-side registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matched_reg   <= '0;
            next_id_reg   <= '0;
            sticky_reg    <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((cmd.op == igbt_pkg::OP_EMIT) || (cmd.op == igbt_pkg::OP_EMIT_EMPTY))
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            case (cmd.op)
                igbt_pkg::OP_INIT:      found_reg <= 1'b0;
                igbt_pkg::OP_IOU_E:
                begin
                    if (better)
                        found_reg <= 1'b1;
                end
                igbt_pkg::OP_MATCH:     matched_reg[widx] <= 1'b1;
                igbt_pkg::OP_DROP:      sticky_reg <= 1'b1;
                igbt_pkg::OP_APPEND:    next_id_reg <= 16'(next_id_reg + 1'b1);
                igbt_pkg::OP_CLR_MATCH: matched_reg <= '0;
                igbt_pkg::OP_EMIT:
                begin
                    if (cmd.last)
                        sticky_reg <= 1'b0;
                end
                igbt_pkg::OP_EMIT_EMPTY: sticky_reg <= 1'b0;
                default: ;
            endcase
        end
    end

    // Payload registers and stores
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            igbt_pkg::OP_LOAD:
            begin
                det_x_reg <= box_x;
                det_y_reg <= box_y;
                det_w_reg <= box_w;
                det_h_reg <= box_h;
            end
            igbt_pkg::OP_INIT:
            begin
                da_reg     <= det_w_reg * det_h_reg;
                best_i_reg <= {23'd0, thresh_reg};
                best_u_reg <= 33'd256;
            end
            igbt_pkg::OP_IOU_A:
            begin
                ow_reg   <= ov_w[15:0];
                oh_reg   <= ov_h[15:0];
                skip_reg <= t_matched || ov_empty;
                ta_reg   <= t_w * t_h;
            end
            igbt_pkg::OP_IOU_B: inter_reg <= ow_reg * oh_reg;
            igbt_pkg::OP_IOU_C:
                uni_reg <= {1'b0, da_reg} + {1'b0, ta_reg} - {1'b0, inter_reg};
            igbt_pkg::OP_IOU_D:
            begin
                prod1_reg <= inter_reg * best_u_reg[31:0];
                prod2_reg <= best_i_reg * uni_reg[31:0];
            end
            igbt_pkg::OP_IOU_E:
            begin
                if (better)
                begin
                    best_i_reg   <= inter_reg;
                    best_u_reg   <= uni_reg;
                    best_idx_reg <= cmd.rd_idx;
                end
            end
            igbt_pkg::OP_EMA:
            begin
                for (int k = 0; k < 4; k++)
                    nb_reg[k] <= ema_new[k];
            end
            igbt_pkg::OP_MATCH:
            begin
                bx_mem[widx]   <= nb_reg[0];
                by_mem[widx]   <= nb_reg[1];
                bw_mem[widx]   <= nb_reg[2];
                bh_mem[widx]   <= nb_reg[3];
                vx_mem[widx]   <= mvx;
                vy_mem[widx]   <= mvy;
                lost_mem[widx] <= 8'd0;
            end
            igbt_pkg::OP_PUSH:
            begin
                px_mem[cmd.pend_idx] <= det_x_reg;
                py_mem[cmd.pend_idx] <= det_y_reg;
                pw_mem[cmd.pend_idx] <= det_w_reg;
                ph_mem[cmd.pend_idx] <= det_h_reg;
            end
            igbt_pkg::OP_SCAN:
            begin
                if (keep)
                begin
                    id_mem[widx]   <= t_id;
                    bx_mem[widx]   <= t_x;
                    by_mem[widx]   <= t_y;
                    bw_mem[widx]   <= t_w;
                    bh_mem[widx]   <= t_h;
                    vx_mem[widx]   <= t_vx;
                    vy_mem[widx]   <= t_vy;
                    lost_mem[widx] <= lost_n;
                end
            end
            igbt_pkg::OP_APPEND:
            begin
                id_mem[widx]   <= 16'(next_id_reg + 1'b1);
                bx_mem[widx]   <= px_mem[cmd.pend_idx];
                by_mem[widx]   <= py_mem[cmd.pend_idx];
                bw_mem[widx]   <= pw_mem[cmd.pend_idx];
                bh_mem[widx]   <= ph_mem[cmd.pend_idx];
                vx_mem[widx]   <= '0;
                vy_mem[widx]   <= '0;
                lost_mem[widx] <= 8'd0;
            end
            igbt_pkg::OP_EMIT:
            begin
                bx_mem[widx]  <= pr_x;
                by_mem[widx]  <= pr_y;
                vx_mem[widx]  <= pr_vx;
                vy_mem[widx]  <= pr_vy;
                track_valid   <= 1'b1;
                track_id      <= t_id;
                out_x         <= pr_x;
                out_y         <= pr_y;
                out_w         <= t_w;
                out_h         <= t_h;
                vel_x         <= pr_vx;
                vel_y         <= pr_vy;
                lost_count    <= t_lost;
                dropped_flag  <= sticky_reg;
                last          <= cmd.last;
            end
            igbt_pkg::OP_EMIT_EMPTY:
            begin
                track_valid  <= 1'b0;
                track_id     <= '0;
                out_x        <= '0;
                out_y        <= '0;
                out_w        <= '0;
                out_h        <= '0;
                vel_x        <= '0;
                vel_y        <= '0;
                lost_count   <= '0;
                dropped_flag <= sticky_reg;
                last         <= 1'b1;
            end
            default: ;
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign status.found    = found_reg;
    assign status.keep     = keep;
    assign status.out_busy = out_valid_reg && out_stall;

endmodule

### design/iou_greedy_box_tracker.sv
// ----------------------------------------------------------------------------
// iou_greedy_box_tracker
// Greedy IoU multi-object box tracker, top level.
//
// One request item is taken at a time; in_stall stays high until it is done.
// A detection is sequenced after it is accepted: a set-up step for the
// search, then for each of the N tracks a five-step IoU sequence
// (overlap, intersection product, union, two cross products, compare),
// a closing step for the search, the EMA update and the match write.
// An unmatched detection takes no EMA update or match write; it is pushed
// to the pending store, or dropped when that store is full. End of frame
// ages and compacts the tracks, then appends the pending boxes, one track
// or one pending box a cycle. Predict emits one result item a cycle while
// out_stall does not hold the output register, one per track (one for an
// empty table). Clear empties the track table. No clearing pass after reset.
// ----------------------------------------------------------------------------
module iou_greedy_box_tracker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic signed [15:0] box_x,
    input  logic signed [15:0] box_y,
    input  logic [15:0]        box_w,
    input  logic [15:0]        box_h,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               track_valid,
    output logic [15:0]        track_id,
    output logic signed [15:0] out_x,
    output logic signed [15:0] out_y,
    output logic [15:0]        out_w,
    output logic [15:0]        out_h,
    output logic signed [15:0] vel_x,
    output logic signed [15:0] vel_y,
    output logic [7:0]         lost_count,
    output logic               dropped_flag,
    output logic               last,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [8:0]         cfg_data
);

    igbt_pkg::dp_cmd_t    cmd;
    igbt_pkg::dp_status_t status;

    // Sequencer
    igbt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd)
    );

    // Stores and arithmetic
    igbt_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .box_x        (box_x),
        .box_y        (box_y),
        .box_w        (box_w),
        .box_h        (box_h),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .track_valid  (track_valid),
        .track_id     (track_id),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_w        (out_w),
        .out_h        (out_h),
        .vel_x        (vel_x),
        .vel_y        (vel_y),
        .lost_count   (lost_count),
        .dropped_flag (dropped_flag),
        .last         (last)
    );

endmodule

### design/igbt_checker.sv
// ----------------------------------------------------------------------------
// igbt_checker
// Port-level checks of the tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module igbt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        track_valid,
    input logic [15:0] track_id,
    input logic        last
);

    // A pending result item stays offered
    `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "out_valid dropped")

    // A stalled result keeps its id
    `ASSERT_NXT(a_id_hold, clk, rst_n, out_valid && out_stall, $stable(track_id), "track_id changed")

    // Every accepted request sets in_stall in the cycle after it is taken
    `ASSERT_NXT(a_busy, clk, rst_n, in_valid && !in_stall, in_stall, "request not sequenced")

    // The empty-table item is the only and final one of its run
    `ASSERT_IMP(a_empty_last, clk, rst_n, out_valid && !track_valid, last, "empty item not last")

endmodule

bind iou_greedy_box_tracker igbt_checker u_igbt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .track_valid (track_valid),
    .track_id    (track_id),
    .last        (last)
);
